// ----- design/cpfl_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the chunk pool free list.
package cpfl_pkg;

  localparam int MAX_CHUNKS = 256;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int LINK_W     = IDX_W + 1;

  localparam int FUNC_W  = 2;
  localparam int CHUNK_W = 8;
  localparam int CNT_W   = 9;
  localparam int SIZE_W  = 13;
  localparam int OFS_W   = 20;
  localparam int CFG_W   = 13;
  localparam int CFGI_W  = 1;

  // link value meaning no successor / empty list
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_CHUNKS);

  typedef enum logic [FUNC_W-1:0] {
    FN_REBUILD,
    FN_TAKE,
    FN_REMOVE,
    FN_TEST
  } func_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_CHUNK_COUNT,
    CFG_CHUNK_SIZE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_REBUILD,
    ST_TAKE,
    ST_TAKE_HEAD,
    ST_RM,
    ST_RM_HEAD,
    ST_RM_WALK,
    ST_RM_LINK,
    ST_TEST,
    ST_TEST_WALK,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_HEAD,
    RS_CHUNK
  } res_sel_t;

  typedef enum logic {
    AS_HEAD,
    AS_DATA
  } addr_sel_t;

  typedef struct packed {
    logic      cap_in;
    logic      sweep_load;
    logic      sweep_step;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      cur_from_head;
    logic      cur_from_data;
    logic      head_adv;
    logic      link_wr;
    logic      res_load;
    res_sel_t  res_sel;
    logic      ok_load;
    logic      ok_val;
    logic      out_load;
  } cpfl_cmd_t;

  typedef struct packed {
    logic head_null;
    logic head_hit;
    logic data_null;
    logic data_hit;
    logic sweep_last;
    logic out_free;
  } cpfl_sts_t;

endpackage

// ----- design/cpfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/cpfl_dp.sv -----
// Datapath: config registers, link memory, head and count, walk cursor and result register.
module cpfl_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cpfl_pkg::cpfl_cmd_t            cmd,
  output cpfl_pkg::cpfl_sts_t            sts,
  input  logic [cpfl_pkg::CHUNK_W-1:0]   in_chunk,
  input  logic                           cfg_we,
  input  logic [cpfl_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [cpfl_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [cpfl_pkg::CHUNK_W-1:0]   out_result_chunk,
  output logic [cpfl_pkg::OFS_W-1:0]     out_chunk_offset,
  output logic                           out_success,
  output logic                           out_list_empty,
  output logic [cpfl_pkg::CNT_W-1:0]     out_free_count
);

  localparam int LW = cpfl_pkg::LINK_W;
  localparam int IW = cpfl_pkg::IDX_W;
  localparam int PW = cpfl_pkg::CHUNK_W + cpfl_pkg::SIZE_W;

  logic [cpfl_pkg::CNT_W-1:0]   cnt_cfg_r, cnt_cfg_nxt;
  logic [cpfl_pkg::SIZE_W-1:0]  size_cfg_r, size_cfg_nxt;
  logic [cpfl_pkg::CHUNK_W-1:0] chunk_r;
  logic [LW-1:0]                head_r, head_nxt;
  logic [LW-1:0]                count_r, count_nxt;
  logic [IW-1:0]                cur_r;
  logic [LW-1:0]                sw_idx_r, sw_idx_nxt;
  logic [LW-1:0]                sw_n_r, sw_n_nxt;
  logic [LW-1:0]                sw_next;
  logic [LW-1:0]                pool_n;
  logic [cpfl_pkg::CHUNK_W-1:0] res_r;
  logic                         ok_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [cpfl_pkg::CHUNK_W-1:0] o_chunk_r;
  logic [cpfl_pkg::OFS_W-1:0]   o_ofs_r;
  logic                         o_ok_r, o_empty_r;
  logic [cpfl_pkg::CNT_W-1:0]   o_cnt_r;
  logic [PW-1:0]                prod;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0] ram_wdata, rd_data;

  cpfl_ram #(
    .WIDTH (LW),
    .DEPTH (cpfl_pkg::MAX_CHUNKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // saturate the programmed chunk count to 1..MAX_CHUNKS
  always_comb begin
    if (cnt_cfg_r == '0) begin
      pool_n = LW'(1);
    end else if (32'(cnt_cfg_r) > cpfl_pkg::MAX_CHUNKS) begin
      pool_n = LW'(cpfl_pkg::MAX_CHUNKS);
    end else begin
      pool_n = LW'(cnt_cfg_r);
    end
  end

  assign sw_next = sw_idx_r + LW'(1);

  assign ram_we    = cmd.sweep_step | cmd.link_wr;
  assign ram_waddr = cmd.sweep_step ? sw_idx_r[IW-1:0] : cur_r;
  assign ram_wdata = cmd.sweep_step ? ((sw_next == sw_n_r) ? cpfl_pkg::NO_LINK : sw_next)
                                    : rd_data;
  assign ram_re    = cmd.rd_en;
  assign ram_raddr = (cmd.rd_sel == cpfl_pkg::AS_HEAD) ? head_r[IW-1:0] : rd_data[IW-1:0];

  assign sts.head_null  = (head_r == cpfl_pkg::NO_LINK);
  assign sts.head_hit   = (head_r == LW'(chunk_r));
  assign sts.data_null  = (rd_data == cpfl_pkg::NO_LINK);
  assign sts.data_hit   = (rd_data == LW'(chunk_r));
  assign sts.sweep_last = (sw_next == sw_n_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    cnt_cfg_nxt  = cnt_cfg_r;
    size_cfg_nxt = size_cfg_r;
    if (cfg_we) begin
      unique case (cpfl_pkg::cfg_idx_t'(cfg_index))
        cpfl_pkg::CFG_CHUNK_COUNT: cnt_cfg_nxt  = cfg_wdata[cpfl_pkg::CNT_W-1:0];
        cpfl_pkg::CFG_CHUNK_SIZE:  size_cfg_nxt = cfg_wdata[cpfl_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw_idx_nxt = sw_idx_r;
    sw_n_nxt   = sw_n_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    if (cmd.sweep_load) begin
      sw_idx_nxt = '0;
      sw_n_nxt   = pool_n;
    end else if (cmd.sweep_step) begin
      sw_idx_nxt = sw_next;
      if (sw_next == sw_n_r) begin
        head_nxt  = '0;
        count_nxt = sw_n_r;
      end
    end
    if (cmd.head_adv) begin
      head_nxt = rd_data;
    end
    // drop one from the count whenever a chunk leaves the list
    if ((cmd.head_adv || cmd.link_wr) && count_r != '0) begin
      count_nxt = count_r - LW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign prod = PW'(res_r) * PW'(size_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r   <= cpfl_pkg::CNT_W'(cpfl_pkg::MAX_CHUNKS);
      size_cfg_r  <= cpfl_pkg::SIZE_W'(64);
      sw_idx_r    <= '0;
      sw_n_r      <= LW'(cpfl_pkg::MAX_CHUNKS);
      head_r      <= '0;
      count_r     <= LW'(cpfl_pkg::MAX_CHUNKS);
      out_valid_r <= 1'b0;
    end else begin
      cnt_cfg_r   <= cnt_cfg_nxt;
      size_cfg_r  <= size_cfg_nxt;
      sw_idx_r    <= sw_idx_nxt;
      sw_n_r      <= sw_n_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      chunk_r <= in_chunk;
    end
    if (cmd.cur_from_head) begin
      cur_r <= head_r[IW-1:0];
    end else if (cmd.cur_from_data) begin
      cur_r <= rd_data[IW-1:0];
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        cpfl_pkg::RS_HEAD:  res_r <= cpfl_pkg::CHUNK_W'(head_r);
        cpfl_pkg::RS_CHUNK: res_r <= chunk_r;
        default:            res_r <= '0;
      endcase
    end
    if (cmd.ok_load) begin
      ok_r <= cmd.ok_val;
    end
    if (cmd.out_load) begin
      o_chunk_r <= res_r;
      o_ofs_r   <= prod[cpfl_pkg::OFS_W-1:0];
      o_ok_r    <= ok_r;
      o_empty_r <= (head_r == cpfl_pkg::NO_LINK);
      o_cnt_r   <= cpfl_pkg::CNT_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_chunk = o_chunk_r;
  assign out_chunk_offset = o_ofs_r;
  assign out_success      = o_ok_r;
  assign out_list_empty   = o_empty_r;
  assign out_free_count   = o_cnt_r;

endmodule

// ----- design/cpfl_ctrl.sv -----
// Controller: sequences rebuild sweeps, head takes and link walks over the datapath.
module cpfl_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cpfl_pkg::FUNC_W-1:0]   in_func,
  input  cpfl_pkg::cpfl_sts_t           sts,
  output cpfl_pkg::cpfl_cmd_t           cmd
);

  cpfl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpfl_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != cpfl_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      cpfl_pkg::ST_INIT, cpfl_pkg::ST_REBUILD: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          if (state_r == cpfl_pkg::ST_INIT) begin
            state_nxt = cpfl_pkg::ST_IDLE;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = cpfl_pkg::RS_ZERO;
            cmd.ok_load  = 1'b1;
            cmd.ok_val   = 1'b1;
            state_nxt    = cpfl_pkg::ST_REPORT;
          end
        end
      end
      cpfl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          unique case (cpfl_pkg::func_t'(in_func))
            cpfl_pkg::FN_REBUILD: begin
              cmd.sweep_load = 1'b1;
              state_nxt      = cpfl_pkg::ST_REBUILD;
            end
            cpfl_pkg::FN_TAKE:   state_nxt = cpfl_pkg::ST_TAKE;
            cpfl_pkg::FN_REMOVE: state_nxt = cpfl_pkg::ST_RM;
            default:             state_nxt = cpfl_pkg::ST_TEST;
          endcase
        end
      end
      cpfl_pkg::ST_TAKE: begin
        cmd.res_load = 1'b1;
        cmd.ok_load  = 1'b1;
        if (sts.head_null) begin
          cmd.res_sel = cpfl_pkg::RS_ZERO;
          state_nxt   = cpfl_pkg::ST_REPORT;
        end else begin
          cmd.res_sel = cpfl_pkg::RS_HEAD;
          cmd.ok_val  = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = cpfl_pkg::AS_HEAD;
          state_nxt   = cpfl_pkg::ST_TAKE_HEAD;
        end
      end
      cpfl_pkg::ST_TAKE_HEAD, cpfl_pkg::ST_RM_HEAD: begin
        cmd.head_adv = 1'b1;
        state_nxt    = cpfl_pkg::ST_REPORT;
      end
      cpfl_pkg::ST_RM: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = cpfl_pkg::RS_CHUNK;
        cmd.ok_load  = 1'b1;
        if (sts.head_null) begin
          state_nxt = cpfl_pkg::ST_REPORT;
        end else begin
          cmd.rd_en         = 1'b1;
          cmd.rd_sel        = cpfl_pkg::AS_HEAD;
          cmd.cur_from_head = 1'b1;
          if (sts.head_hit) begin
            cmd.ok_val = 1'b1;
            state_nxt  = cpfl_pkg::ST_RM_HEAD;
          end else begin
            state_nxt  = cpfl_pkg::ST_RM_WALK;
          end
        end
      end
      cpfl_pkg::ST_RM_WALK: begin
        // read data is the successor of the cursor; fetch its own link either way
        if (sts.data_null) begin
          state_nxt = cpfl_pkg::ST_REPORT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = cpfl_pkg::AS_DATA;
          if (sts.data_hit) begin
            state_nxt = cpfl_pkg::ST_RM_LINK;
          end else begin
            cmd.cur_from_data = 1'b1;
          end
        end
      end
      cpfl_pkg::ST_RM_LINK: begin
        cmd.link_wr = 1'b1;
        cmd.ok_load = 1'b1;
        cmd.ok_val  = 1'b1;
        state_nxt   = cpfl_pkg::ST_REPORT;
      end
      cpfl_pkg::ST_TEST: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = cpfl_pkg::RS_CHUNK;
        cmd.ok_load  = 1'b1;
        if (sts.head_null) begin
          state_nxt = cpfl_pkg::ST_REPORT;
        end else if (sts.head_hit) begin
          cmd.ok_val = 1'b1;
          state_nxt  = cpfl_pkg::ST_REPORT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = cpfl_pkg::AS_HEAD;
          state_nxt  = cpfl_pkg::ST_TEST_WALK;
        end
      end
      cpfl_pkg::ST_TEST_WALK: begin
        cmd.ok_load = 1'b1;
        if (sts.data_null) begin
          state_nxt = cpfl_pkg::ST_REPORT;
        end else if (sts.data_hit) begin
          cmd.ok_val = 1'b1;
          state_nxt  = cpfl_pkg::ST_REPORT;
        end else begin
          cmd.ok_load = 1'b0;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = cpfl_pkg::AS_DATA;
        end
      end
      cpfl_pkg::ST_REPORT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = cpfl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpfl_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- design/chunk_pool_free_list_top.sv -----
// Top level of the chunk pool free list: controller plus datapath.
//
// Input channel (in_valid/in_stall) carries one command beat: in_func selects
// rebuild, take head, remove chunk or test chunk, in_chunk names the chunk.
// Every beat gives exactly one result beat on out_valid/out_stall with the
// chunk, its byte offset, a success flag, the empty flag and the free count.
// Items are processed one at a time; the link memory is one registered-read
// RAM port, so a walk reads the listed chunks one after another, and a
// rebuild writes one link per chunk.
// A new beat is taken once the previous result sits in the output register,
// even if that register is still held by out_stall; a stalled result holds
// its value and the next result waits behind it.
// After reset the link memory is chained over MAX_CHUNKS chunks by a sweep;
// in_stall stays high during the sweep, config writes are taken throughout.
// Config writes (cfg_we, cfg_index, cfg_wdata) apply at once; a new
// chunk_count takes effect at the next rebuild.
module chunk_pool_free_list_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cpfl_pkg::FUNC_W-1:0]   in_func,
  input  logic [cpfl_pkg::CHUNK_W-1:0]  in_chunk,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cpfl_pkg::CHUNK_W-1:0]  out_result_chunk,
  output logic [cpfl_pkg::OFS_W-1:0]    out_chunk_offset,
  output logic                          out_success,
  output logic                          out_list_empty,
  output logic [cpfl_pkg::CNT_W-1:0]    out_free_count,
  input  logic                          cfg_we,
  input  logic [cpfl_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [cpfl_pkg::CFG_W-1:0]    cfg_wdata
);

  cpfl_pkg::cpfl_cmd_t cmd;
  cpfl_pkg::cpfl_sts_t sts;

  cpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpfl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_chunk         (in_chunk),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_chunk (out_result_chunk),
    .out_chunk_offset (out_chunk_offset),
    .out_success      (out_success),
    .out_list_empty   (out_list_empty),
    .out_free_count   (out_free_count)
  );

endmodule

// ----- design/cpfl_checker.sv -----
// Port-level checker for the chunk pool free list, bound to the top level.
module cpfl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [cpfl_pkg::FUNC_W-1:0]   in_func,
  input logic [cpfl_pkg::CHUNK_W-1:0]  in_chunk,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cpfl_pkg::CHUNK_W-1:0]  out_result_chunk,
  input logic [cpfl_pkg::OFS_W-1:0]    out_chunk_offset,
  input logic                          out_success,
  input logic                          out_list_empty,
  input logic [cpfl_pkg::CNT_W-1:0]    out_free_count,
  input logic                          cfg_we,
  input logic [cpfl_pkg::CFGI_W-1:0]   cfg_index,
  input logic [cpfl_pkg::CFG_W-1:0]    cfg_wdata
);

  // the init sweep blocks input right after reset
  a_init_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input accepted during the reset sweep");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // one item at a time: an accepted beat closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat accepted while an item is in progress");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_list_empty == (out_free_count == '0)))
    else $error("empty flag disagrees with free count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_free_count) <= cpfl_pkg::MAX_CHUNKS))
    else $error("free count beyond pool size");

endmodule

bind chunk_pool_free_list_top cpfl_checker u_cpfl_checker (.*);
